// ===== src/tprs_pkg.sv =====
// Package for the timer prescaler and reload search block.
// Holds widths, constants and the controller/datapath command and status types.
// No dependencies.
`default_nettype none

package tprs_pkg;

    localparam int MS_W      = 16;
    localparam int CLK_W     = 16;
    localparam int NUM_W     = 32;
    localparam int PRESC_W   = 12;
    localparam int DIV_W     = PRESC_W + 1;
    localparam int LIM_W     = DIV_W + 16;
    localparam int RELOAD_W  = 16;
    localparam int CNT_W     = $clog2(NUM_W + 1);

    localparam int PRESCALER_LIMIT_DEFAULT = 4095;

    localparam logic [CLK_W-1:0]    REF_CLOCK_RESET = 16'd13560;
    localparam logic [RELOAD_W-1:0] RELOAD_MAX      = 16'hFFFF;
    localparam logic [LIM_W-1:0]    LIMIT_INIT      = LIM_W'(RELOAD_MAX);
    localparam logic [LIM_W-1:0]    LIMIT_STEP      = LIM_W'(2 * 32'hFFFF);
    localparam logic [CNT_W-1:0]    DIV_STEPS       = CNT_W'(NUM_W);

    typedef struct packed {
        logic capture;
        logic load;
        logic step;
        logic div_start;
        logic fit;
    } tprs_cmd_t;

    typedef struct packed {
        logic fit;
        logic last;
        logic div_done;
    } tprs_sts_t;

endpackage

`default_nettype wire

// ===== src/tprs_dp.sv =====
// Datapath: config register, tick count multiply, prescaler search, restoring divider.
// Depends on tprs_pkg.
`default_nettype none

module tprs_dp
    import tprs_pkg::*;
#(
    parameter int PRESCALER_LIMIT = PRESCALER_LIMIT_DEFAULT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    input  wire logic [CLK_W-1:0]      cfg_data,
    input  wire logic [MS_W-1:0]       timeout_ms,
    input  wire tprs_cmd_t             cmd,
    output tprs_sts_t                  sts,
    output logic [PRESC_W-1:0]         prescaler,
    output logic [RELOAD_W-1:0]        reload,
    output logic                       no_fit
);

    localparam logic [PRESC_W-1:0] P_LAST = PRESC_W'(PRESCALER_LIMIT - 1);
    localparam logic [PRESC_W-1:0] P_MAX  = PRESC_W'(PRESCALER_LIMIT);

    logic [CLK_W-1:0]   ref_reg;
    logic [MS_W-1:0]    ms_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [PRESC_W-1:0] p_reg;
    logic [DIV_W-1:0]   d_reg;
    logic [LIM_W-1:0]   limit_reg;
    logic [DIV_W-1:0]   rem_reg;
    logic [NUM_W-1:0]   quo_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [PRESC_W-1:0] presc_reg;
    logic               no_fit_reg;

    logic [NUM_W-1:0]   prod;
    logic [DIV_W:0]     shifted;
    logic [DIV_W:0]     diff;

    assign prod    = NUM_W'(ms_reg) * NUM_W'(ref_reg);
    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign diff    = shifted - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg <= REF_CLOCK_RESET;
            cnt_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
                ref_reg <= cfg_data;
            if (cmd.div_start)
                cnt_reg <= DIV_STEPS;
            else if (cnt_reg != '0)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            ms_reg <= timeout_ms;
        if (cmd.load)
        begin
            num_reg   <= prod - NUM_W'(1);
            p_reg     <= '0;
            d_reg     <= DIV_W'(1);
            limit_reg <= LIMIT_INIT;
        end
        else if (cmd.step)
        begin
            p_reg     <= p_reg + PRESC_W'(1);
            d_reg     <= d_reg + DIV_W'(2);
            limit_reg <= limit_reg + LIMIT_STEP;
        end
        if (cmd.div_start)
        begin
            rem_reg    <= '0;
            quo_reg    <= num_reg;
            presc_reg  <= cmd.fit ? p_reg : P_MAX;
            no_fit_reg <= !cmd.fit;
        end
        else if (cnt_reg != '0)
        begin
            if (!diff[DIV_W])
            begin
                rem_reg <= diff[DIV_W-1:0];
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[DIV_W-1:0];
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign sts.fit      = num_reg < NUM_W'(limit_reg);
    assign sts.last     = p_reg == P_LAST;
    assign sts.div_done = cnt_reg == '0;

    assign prescaler = presc_reg;
    assign reload    = quo_reg[RELOAD_W-1:0];
    assign no_fit    = no_fit_reg;

endmodule

`default_nettype wire

// ===== src/tprs_ctrl.sv =====
// Controller: sequences capture, multiply, search, divide and result strobe.
// Depends on tprs_pkg.
`default_nettype none

module tprs_ctrl
    import tprs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire tprs_sts_t  sts,
    output tprs_cmd_t       cmd,
    output logic            busy,
    output logic            done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SEARCH,
        S_DIV,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.load   = 1'b1;
                state_next = S_SEARCH;
            end
            S_SEARCH:
            begin
                priority if (sts.fit)
                begin
                    cmd.div_start = 1'b1;
                    cmd.fit       = 1'b1;
                    state_next    = S_DIV;
                end
                else if (sts.last)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                    cmd.step = 1'b1;
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    done_next  = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = state_reg != S_IDLE;
    assign done = done_reg;

endmodule

`default_nettype wire

// ===== src/timer_prescaler_reload_search.sv =====
// Top level of the timer prescaler and reload search block.
// Instantiates tprs_ctrl and tprs_dp; depends on tprs_pkg.
//
// Usage:
//   Request: drive timeout_ms and pulse start; the request is taken at a rising
//   edge with start high and busy low. busy stays high until the result is out.
//   Result: prescaler, reload and no_fit are valid while done is high, for
//   exactly one cycle. The receiver cannot stall; the result is taken then.
//   Config: ref_clock_khz is written through cfg_valid/cfg_ready/cfg_data;
//   cfg_ready is always high. Write only while busy is low.
//   Timing: an accepted request passes through capture, multiply, search and
//   divide before done; busy drops in the cycle after done. The search tests
//   one prescaler per cycle by comparing the tick count against 0xFFFF times
//   the divisor; the final reload comes from a restoring divider that retires
//   one quotient bit per cycle across the 32-bit quotient.
//   Reset: rst_n low clears the controller, aborts any request and sets
//   ref_clock_khz to 13560.
`default_nettype none

module timer_prescaler_reload_search
    import tprs_pkg::*;
#(
    parameter int PRESCALER_LIMIT = PRESCALER_LIMIT_DEFAULT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [MS_W-1:0]       timeout_ms,
    output logic                       done,
    output logic [PRESC_W-1:0]         prescaler,
    output logic [RELOAD_W-1:0]        reload,
    output logic                       no_fit,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CLK_W-1:0]      cfg_data
);

    tprs_cmd_t cmd;
    tprs_sts_t sts;

    assign cfg_ready = 1'b1;

    tprs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    tprs_dp #(
        .PRESCALER_LIMIT (PRESCALER_LIMIT)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .timeout_ms (timeout_ms),
        .cmd        (cmd),
        .sts        (sts),
        .prescaler  (prescaler),
        .reload     (reload),
        .no_fit     (no_fit)
    );

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe outside a request");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_no_fit_presc: assert property (@(posedge clk) disable iff (!rst_n)
        (done && no_fit) |-> (prescaler == PRESC_W'(PRESCALER_LIMIT)))
        else $error("no fit without limit prescaler");

    a_fit_reload: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !no_fit) |-> (reload != RELOAD_MAX))
        else $error("fitting reload at maximum");

endmodule

`default_nettype wire

// ===== bench/timer_prescaler_reload_search_tb.sv =====
// Regression bench for timer_prescaler_reload_search: timeout requests under several
// reference clock settings, each result checked against a prescaler search predictor.
// Depends on tprs_pkg and the timer_prescaler_reload_search RTL.

module timer_prescaler_reload_search_tb
    import tprs_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRESCALER_LIMIT = PRESCALER_LIMIT_DEFAULT;

    typedef enum logic [1:0] {
        JOB_REQUEST,
        JOB_CLOCK,
        JOB_DRAIN
    } job_kind_t;

    typedef struct {
        job_kind_t   kind;
        logic [15:0] value;
        int unsigned gap_pct;
    } job_t;

    typedef struct packed {
        logic [PRESC_W-1:0]  prescaler;
        logic [RELOAD_W-1:0] reload;
        logic                no_fit;
    } timer_setting_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [MS_W-1:0]     timeout_ms = '0;
    logic                done;
    logic [PRESC_W-1:0]  prescaler;
    logic [RELOAD_W-1:0] reload;
    logic                no_fit;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CLK_W-1:0]    cfg_data = '0;

    job_t           jobs[$];
    timer_setting_t settings_due[$];
    logic [CLK_W-1:0] clock_khz = REF_CLOCK_RESET;

    int unsigned requests_issued = 0;
    int unsigned requests_taken = 0;
    int unsigned clock_writes_issued = 0;
    int unsigned clock_writes_taken = 0;
    int unsigned no_fit_seen = 0;
    int unsigned errors = 0;

    timer_prescaler_reload_search #(
        .PRESCALER_LIMIT(PRESCALER_LIMIT)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .timeout_ms (timeout_ms),
        .done       (done),
        .prescaler  (prescaler),
        .reload     (reload),
        .no_fit     (no_fit),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 0;
    end

    function automatic timer_setting_t search_timer_setting(input logic [MS_W-1:0] ms,
                                                             input logic [CLK_W-1:0] khz);
        logic [NUM_W-1:0] ticks;
        logic [NUM_W-1:0] quot;
        logic [NUM_W-1:0] p;
        timer_setting_t   found;
        ticks = NUM_W'(ms) * NUM_W'(khz) - 1;
        quot = '0;
        found.no_fit = 1'b1;
        for (p = 0; p < PRESCALER_LIMIT; p++)
        begin
            quot = ticks / ((p << 1) + 1);
            if (quot < NUM_W'(RELOAD_MAX))
            begin
                found.no_fit = 1'b0;
                break;
            end
        end
        found.prescaler = p[PRESC_W-1:0];
        found.reload = quot[RELOAD_W-1:0];
        return found;
    endfunction

    function void report(input string what, input int unsigned want, input int unsigned got);
        errors++;
        if (errors <= 10)
            $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, want, got);
    endfunction

    task automatic add_request(input logic [15:0] ms, input int unsigned gap);
        jobs.push_back('{JOB_REQUEST, ms, gap});
    endtask

    task automatic add_clock(input logic [15:0] khz);
        jobs.push_back('{JOB_CLOCK, khz, 0});
    endtask

    task automatic add_drain();
        jobs.push_back('{JOB_DRAIN, 16'd0, 0});
    endtask

    // hold start/cfg_valid until taken, then advance to the next job
    always @(negedge clk)
    begin : drive
        logic go_start;
        logic go_cfg;
        logic idle;
        job_t job;
        if (rst_n)
        begin
            go_start = start && (requests_taken != requests_issued);
            go_cfg = cfg_valid && (clock_writes_taken != clock_writes_issued);
            idle = (settings_due.size() == 0) && !busy;
            if (!go_start && !go_cfg && jobs.size() > 0)
            begin
                job = jobs[0];
                case (job.kind)
                    JOB_REQUEST:
                        if ($urandom_range(99) >= job.gap_pct)
                        begin
                            timeout_ms <= job.value;
                            go_start = 1'b1;
                            requests_issued++;
                            void'(jobs.pop_front());
                        end
                    JOB_CLOCK:
                        if (idle)
                        begin
                            cfg_data <= job.value;
                            go_cfg = 1'b1;
                            clock_writes_issued++;
                            void'(jobs.pop_front());
                        end
                    default:
                        if (idle)
                            void'(jobs.pop_front());
                endcase
            end
            if (!go_start)
                timeout_ms <= MS_W'($urandom);
            start <= go_start;
            cfg_valid <= go_cfg;
        end
    end

    always @(posedge clk)
    begin : watch
        timer_setting_t want;
        timer_setting_t got;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                clock_khz = cfg_data;
                clock_writes_taken++;
            end
            if (done)
            begin
                got = '{prescaler, reload, no_fit};
                if (no_fit)
                    no_fit_seen++;
                if (settings_due.size() == 0)
                    report("unexpected result, prescaler", 0, got.prescaler);
                else
                begin
                    want = settings_due.pop_front();
                    if (got.prescaler !== want.prescaler)
                        report("prescaler", want.prescaler, got.prescaler);
                    if (got.reload !== want.reload)
                        report("reload", want.reload, got.reload);
                    if (got.no_fit !== want.no_fit)
                        report("no_fit", want.no_fit, got.no_fit);
                end
            end
            if (start && !busy)
            begin
                settings_due.push_back(search_timer_setting(timeout_ms, clock_khz));
                requests_taken++;
            end
        end
    end

    initial
    begin
        int unsigned gap;
        add_request(16'd0, 32);
        add_request(16'd1, 32);
        add_request(16'd4, 32);
        add_request(16'd5, 32);
        add_request(16'd39577, 32);
        add_request(16'd39578, 32);
        add_request(16'hFFFF, 32);
        add_request(16'h5555, 32);
        add_request(16'hAAAA, 32);
        add_clock(16'd1);
        add_request(16'hFFFF, 32);
        add_request(16'd1, 32);
        add_request(16'd0, 32);
        add_clock(16'd2);
        add_request(16'h8000, 32);
        add_request(16'h7FFF, 32);
        add_clock(16'hFFFF);
        add_request(16'hFFFF, 32);
        add_request(16'd1, 32);
        add_request(16'h0100, 32);
        add_clock(16'd0);
        add_request(16'd1234, 32);
        add_request(16'd0, 32);
        for (int ph = 0; ph < 3; ph++)
        begin
            gap = (ph == 0) ? 32 : (ph == 1) ? 72 : 0;
            case (ph)
                0: add_clock(16'($urandom_range(1, 65535)));
                1: add_clock(16'($urandom));
                default: add_clock(16'($urandom_range(1, 200)));
            endcase
            for (int i = 0; i < 27; i++)
            begin
                if (i == 13)
                    add_drain();
                if ($urandom_range(1))
                    add_request(16'($urandom), gap);
                else
                    add_request(16'($urandom_range(0, 3000)), gap);
            end
        end

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        while (jobs.size() != 0 || settings_due.size() != 0 || start)
            @(posedge clk);
        repeat (PRESCALER_LIMIT + 40) @(posedge clk);

        $display("Covered %0d timeout requests (%0d without a fitting prescaler)",
                 requests_taken, no_fit_seen);
        $display("over %0d clock settings; mismatches: %0d, results still outstanding: %0d",
                 clock_writes_taken + 1, errors, settings_due.size());
        if (errors == 0 && settings_due.size() == 0)
            $display("timer_prescaler_reload_search regression: pass");
        else
            $display("timer_prescaler_reload_search regression: fail");
        $finish;
    end

    initial
    begin
        #80_000_000;
        $display("Timed out with %0d results outstanding", settings_due.size());
        $display("timer_prescaler_reload_search regression: fail");
        $finish;
    end

endmodule
